>>> rtl/core/pbss_pkg.sv
// ----------------------------------------------------------------------------
// pbss_pkg
// Shared types, constants and the threshold search of the shift selector.
// ----------------------------------------------------------------------------
package pbss_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int NUM_PARTS  = 6;
	localparam int SQUARE_W   = 31;   // (-2^15)^2 = 2^30 fits 31 unsigned bits
	localparam int SUM_W      = 33;   // six squares stay below 2^33
	localparam int SHIFT_W    = 5;
	localparam int COUNT_W    = 16;
	localparam int FIRST_K    = 5;
	localparam int LAST_K     = 15;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET   = SHIFT_W'(17);
	localparam logic [SHIFT_W-1:0] SHIFT_MIN     = SHIFT_W'(FIRST_K + 1);
	localparam logic [SHIFT_W-1:0] SHIFT_DEFAULT = SHIFT_W'(LAST_K + 2);

	typedef logic signed [SAMPLE_W-1:0]  pbss_sample_t;
	typedef pbss_sample_t [NUM_PARTS-1:0] pbss_parts_t;
	typedef logic [SQUARE_W-1:0]         pbss_square_t;
	typedef pbss_square_t [NUM_PARTS-1:0] pbss_squares_t;
	typedef logic [SUM_W-1:0]            pbss_sum_t;
	typedef logic [SHIFT_W-1:0]          pbss_shift_t;

	// Result beat handed from the select stage to the top level.
	typedef struct packed {
		pbss_shift_t shift;
		logic        changed;
	} pbss_result_t;

	// First k in FIRST_K..LAST_K with sum < 3*4^k gives k+1, else LAST_K+2.
	function automatic pbss_shift_t pick_shift(input pbss_sum_t sum);
		pbss_shift_t res;
		pbss_sum_t   thr;
		res = SHIFT_DEFAULT;
		for (int k = LAST_K; k >= FIRST_K; k--) begin
			thr = SUM_W'(3) << (2 * k);
			if (sum < thr)
				res = SHIFT_W'(k + 1);
		end
		return res;
	endfunction

endpackage

>>> rtl/core/power_based_shift_selector.sv
// ----------------------------------------------------------------------------
// power_based_shift_selector
// Picks a barrel shift from the power of three complex samples per beat.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register, from input beat to result beat.
// Throughput: one beat per cycle; each register holds on a stall.
// The skip counter is updated as a beat enters, so decimation follows input order.
// Reset: asynchronous, active low; clears stage valids, the counter and the
// interval, and sets the held shift to 17. Configuration is always ready.
module power_based_shift_selector
	import pbss_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_real, first_imag, second_real, second_imag, third_real, third_imag
	input  logic [95:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// shift_amount [4:0], zero [7:5]
	output logic [7:0]   m_tdata,
	// shift_changed
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	logic [COUNT_W-1:0] interval_q;
	logic [COUNT_W-1:0] skip_cnt_q;
	logic               v_s1, eval_s1;
	pbss_parts_t        parts_s1;
	logic               en_s1, in_beat, eval_d;
	logic               sel_ready;
	pbss_sum_t          pw_sum;
	pbss_result_t       result;

	assign cfg_ready = 1'b1;
	assign en_s1     = !v_s1 || sel_ready;
	assign s_tready  = en_s1;
	assign in_beat   = s_tvalid && s_tready;
	assign eval_d    = !(skip_cnt_q < interval_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
			skip_cnt_q <= '0;
			v_s1       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				interval_q <= cfg_data;
			if (in_beat)
				skip_cnt_q <= eval_d ? '0 : skip_cnt_q + COUNT_W'(1);
			if (en_s1)
				v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			parts_s1 <= pbss_parts_t'(s_tdata);
			eval_s1  <= eval_d;
		end
	end

	pbss_power u_power (
		.in_parts (parts_s1),
		.out_sum  (pw_sum)
	);

	pbss_select u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s1),
		.in_ready   (sel_ready),
		.in_eval    (eval_s1),
		.in_sum     (pw_sum),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {3'b000, result.shift};
	assign m_tuser = result.changed;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:0] >= SHIFT_MIN) && (m_tdata[4:0] <= SHIFT_DEFAULT))
		else $error("shift out of range");

	// An evaluating beat restarts the decimation count.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && eval_d |=> skip_cnt_q == '0)
		else $error("skip counter not cleared on evaluation");

	// A skipped beat advances the count by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && !eval_d |=> skip_cnt_q == $past(skip_cnt_q) + COUNT_W'(1))
		else $error("skip counter did not advance");

	// With an empty result register the input side must be open.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !v_s1 |-> s_tready)
		else $error("input blocked with empty pipeline front");
`endif

endmodule

>>> rtl/core/pbss_power.sv
// ----------------------------------------------------------------------------
// pbss_power
// Power of the three samples of a beat: six squares and their sum.
// ----------------------------------------------------------------------------
module pbss_power
	import pbss_pkg::*;
(
	input  pbss_parts_t in_parts,
	output pbss_sum_t   out_sum
);

	pbss_squares_t sq;

	always_comb begin
		logic signed [2*SAMPLE_W-1:0] p;
		for (int i = 0; i < NUM_PARTS; i++) begin
			p     = in_parts[i] * in_parts[i];
			sq[i] = p[SQUARE_W-1:0];
		end
	end

	// balanced add of the six squares
	assign out_sum = (SUM_W'(sq[0]) + SUM_W'(sq[1])) + (SUM_W'(sq[2]) + SUM_W'(sq[3]))
		+ (SUM_W'(sq[4]) + SUM_W'(sq[5]));

endmodule

>>> rtl/core/pbss_select.sv
// ----------------------------------------------------------------------------
// pbss_select
// Threshold search, held shift and the result register.
// ----------------------------------------------------------------------------
module pbss_select
	import pbss_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         in_eval,
	input  pbss_sum_t    in_sum,
	output logic         out_valid,
	input  logic         out_ready,
	output pbss_result_t out_result
);

	logic         v_s2;
	pbss_result_t res_s2;
	pbss_shift_t  hold_q;
	pbss_shift_t  sel;
	logic         load;
	logic         diff;

	assign in_ready = !v_s2 || out_ready;
	assign load     = in_ready && in_valid;
	assign sel      = pick_shift(in_sum);
	assign diff     = in_eval && (sel != hold_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			hold_q <= SHIFT_RESET;
		end else begin
			if (in_ready)
				v_s2 <= in_valid;
			if (load && diff)
				hold_q <= sel;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2.shift   <= diff ? sel : hold_q;
			res_s2.changed <= diff;
		end
	end

	assign out_valid  = v_s2;
	assign out_result = res_s2;

`ifndef SYNTHESIS
	// A changed beat must actually move the held shift.
	assert property (@(posedge clk) disable iff (!arst_n)
		load && diff |=> hold_q != $past(hold_q))
		else $error("held shift did not move on a change");
`endif

endmodule

>>> tb/pbss_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbss_result_checker
// Watches the sample, result and interval channels of the shift selector,
// predicts the shift and change strobe of every accepted sample beat and
// compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module pbss_result_checker
	import pbss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          results_checked,
	output int          changes_seen
);

	pbss_result_t         expected_shifts[$];
	pbss_result_t         exp_beat;
	pbss_shift_t          fresh_shift;
	pbss_shift_t          held_shift;
	logic [COUNT_W-1:0]   interval;
	logic [COUNT_W-1:0]   skip_cnt;
	int                   errs;
	int                   n_checked;
	int                   n_changes;

	initial begin
		errs      = 0;
		n_checked = 0;
		n_changes = 0;
	end

	assign fail_count      = errs;
	assign pending         = expected_shifts.size();
	assign results_checked = n_checked;
	assign changes_seen    = n_changes;

	// Power of the three samples against 3*4^k, smallest k first.
	function automatic pbss_shift_t power_to_shift(input pbss_parts_t parts);
		longint      power;
		longint      limit;
		pbss_shift_t sel;
		power = 0;
		for (int i = 0; i < NUM_PARTS; i++)
			power += longint'(parts[i]) * longint'(parts[i]);
		sel = SHIFT_DEFAULT;
		for (int k = FIRST_K; k <= LAST_K; k++) begin
			limit = longint'(3) << (2 * k);
			if (power < limit) begin
				sel = SHIFT_W'(k + 1);
				break;
			end
		end
		return sel;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval   = '0;
			skip_cnt   = '0;
			held_shift = SHIFT_RESET;
			expected_shifts.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_shifts.size() == 0) begin
					$error("result beat with nothing expected: shift_amount %0d shift_changed %0d",
						m_tdata[4:0], m_tuser[0]);
					errs++;
				end else begin
					exp_beat = expected_shifts.pop_front();
					n_checked++;
					if (m_tuser[0])
						n_changes++;
					if (m_tdata[4:0] !== exp_beat.shift) begin
						$error("shift_amount mismatch: expected %0d, actual %0d",
							exp_beat.shift, m_tdata[4:0]);
						errs++;
					end
					if (m_tuser[0] !== exp_beat.changed) begin
						$error("shift_changed mismatch: expected %0d, actual %0d",
							exp_beat.changed, m_tuser[0]);
						errs++;
					end
					if (m_tdata[7:5] !== 3'b000) begin
						$error("tdata pad mismatch: expected 0, actual %0d", m_tdata[7:5]);
						errs++;
					end
				end
			end

			if (cfg_valid && cfg_ready)
				interval = cfg_data;

			if (s_tvalid && s_tready) begin
				if (skip_cnt < interval) begin
					// decimated beat: repeat the held shift
					skip_cnt = skip_cnt + 1'b1;
					exp_beat.changed = 1'b0;
				end else begin
					skip_cnt = '0;
					fresh_shift = power_to_shift(s_tdata);
					exp_beat.changed = (fresh_shift != held_shift);
					held_shift = fresh_shift;
				end
				exp_beat.shift = held_shift;
				expected_shifts.push_back(exp_beat);
			end
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream test of the power based shift selector: directed threshold and
// extreme samples, then random sample beats of drifting power under several
// update intervals, with random stalls on both sides and one long sink stall.
// ----------------------------------------------------------------------------
module testbench;
	import pbss_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;

	int fail_count;
	int pending;
	int results_checked;
	int changes_seen;
	int cycle_count = 0;
	int items_sent  = 0;
	int settings    = 0;
	bit quiet       = 1'b0;
	bit hold_req    = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	power_based_shift_selector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	pbss_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.changes_seen    (changes_seen)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sink side: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		int roll;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				roll = $urandom_range(0, 99);
				if (!quiet) begin
					if (roll >= 95)
						stall_left = $urandom_range(10, 40);
					else if (roll >= 70)
						stall_left = $urandom_range(1, 3);
				end
			end
		end
	end

	function automatic pbss_parts_t six(input int a, input int b, input int c,
		input int d, input int e, input int f);
		return {16'(f), 16'(e), 16'(d), 16'(c), 16'(b), 16'(a)};
	endfunction

	// Parts near the given power level, with some full range noise.
	function automatic pbss_parts_t random_parts(input int level);
		pbss_parts_t  parts;
		pbss_sample_t raw;
		int           e;
		for (int i = 0; i < NUM_PARTS; i++) begin
			raw = 16'($urandom);
			if ($urandom_range(0, 4) == 0) begin
				parts[i] = raw;
			end else begin
				e = level - int'($urandom_range(0, 1));
				if (e < 0)
					e = 0;
				parts[i] = raw >>> (15 - e);
			end
		end
		return parts;
	endfunction

	// Call at a falling edge; returns at a falling edge.
	task automatic send_item(input pbss_parts_t parts, input int gap);
		s_tdata  <= parts;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_interval(input logic [15:0] value);
		wait_drained();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic run_phase(input logic [15:0] value, input int count,
		input bit no_idle, input bit long_hold);
		int level;
		write_interval(value);
		quiet = no_idle;
		level = $urandom_range(0, 15);
		if (long_hold)
			hold_req = 1'b1;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				level = $urandom_range(0, 15);
			else
				level = level + int'($urandom_range(0, 2)) - 1;
			if (level < 0)
				level = 0;
			if (level > 15)
				level = 15;
			// keep offering beats while the sink is held off
			send_item(random_parts(level), (long_hold && i < 60) ? 0 : pick_gap());
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_interval(16'd0);
		send_item(six(0, 0, 0, 0, 0, 0), pick_gap());
		send_item(six(0, 0, 0, 0, 0, 0), pick_gap());
		send_item(six(32767, 32767, 32767, 32767, 32767, 32767), pick_gap());
		send_item(six(-32768, -32768, -32768, -32768, -32768, -32768), pick_gap());
		send_item(six(32767, -32768, 32767, -32768, 32767, -32768), pick_gap());
		// sums landing exactly on a threshold and just below it
		send_item(six(32, 0, 32, 0, 32, 0), pick_gap());
		send_item(six(32, 0, 32, 0, 31, 0), pick_gap());
		send_item(six(-128, 0, 0, 128, -128, 0), pick_gap());
		send_item(six(-128, 0, 0, 127, -128, 0), pick_gap());
		send_item(six(1024, 0, 1024, 0, 1024, 0), pick_gap());
		send_item(six(1024, 0, 1024, 0, 1023, 0), pick_gap());
		send_item(six(0, -32768, 0, -32768, 0, -32768), pick_gap());
		send_item(six(0, -32768, 0, -32768, 0, 32767), pick_gap());
		send_item(six(0, 0, 0, 0, -32768, -32768), pick_gap());
		send_item(six(1, -1, 0, 0, 0, 0), pick_gap());
		send_item(six(21845, -21846, 21845, -21846, 21845, -21846), pick_gap());
		send_item(six(-21846, 21845, -21846, 21845, -21846, 21845), pick_gap());
		send_item(six(0, 0, 0, 0, 0, 0), pick_gap());

		run_phase(16'd0, 500, 1'b0, 1'b1);
		run_phase(16'd1, 200, 1'b1, 1'b0);
		run_phase(16'd3, 200, 1'b0, 1'b0);
		run_phase(16'd7, 150, 1'b0, 1'b0);
		run_phase(16'($urandom_range(2, 31)), 250, 1'b0, 1'b0);
		run_phase(16'hFFFF, 150, 1'b0, 1'b0);
		// counter now far above the new interval: next beat re-evaluates
		run_phase(16'd3, 200, 1'b0, 1'b0);
		run_phase(16'd0, 100, 1'b0, 1'b0);

		wait_drained();
		$display("Covered %0d sample beats under %0d interval settings (0 up to 65535).",
			items_sent, settings);
		$display("Checked %0d result beats, %0d of them with a shift change.",
			results_checked, changes_seen);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
